// ----- sv/tws_pkg.sv -----
// shared types and constants of the timing wheel chain scheduler
// used by tws_wheel_mem and timing_wheel_chain_scheduler
package tws_pkg;

  // result kinds carried on the output tuser
  typedef enum logic [1:0] {
    KIND_EXEC     = 2'd0,
    KIND_PLACED   = 2'd1,
    KIND_REJECTED = 2'd2
  } kind_e;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;

  // wheel memory command group
  typedef struct packed {
    logic wr;
    logic clr;
  } mem_cmd_t;

endpackage

// ----- sv/timing_wheel_chain_scheduler.sv -----
// Timing wheel of SLOTS slots with WAYS task entries each, held in one row memory
// with a registered read. A tick reads the current slot's row and emits one result per
// task. An add is buffered; the final add of a chain starts a placement run with a
// setup state. The search checks one wheel row at a time: for each offset it reads the
// row of each action and, for a timed action, wraps the end slot by repeated subtraction
// and reads the end row as well. Once an offset fits, the chain is written, start entry
// and then end entry of each timed action, and a result is emitted. The single memory
// read port is why rows are checked one at a time. Depends on tws_pkg.
module timing_wheel_chain_scheduler #(
  parameter int unsigned SLOTS     = 32,
  parameter int unsigned WAYS      = 4,
  parameter int unsigned CHAIN_LEN = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // task_id[7:0], duration[12:8], end_task_id[20:13]
  input  logic        s_axis_tuser_i,  // operation
  input  logic        s_axis_tlast_i,  // last_action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // task_id_res[7:0], slot[12:8], offset[18:13],
                                       // dropped_actions[22:19]
  output logic [1:0]  m_axis_tuser_o,  // kind
  output logic        m_axis_tlast_o   // last
);

  localparam int unsigned SW    = $clog2(SLOTS);
  localparam int unsigned OW    = SW + 1;
  localparam int unsigned EW    = SW + 6;
  localparam int unsigned ROW_W = WAYS * 8;
  localparam int unsigned WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned CW    = $clog2(CHAIN_LEN + 1);
  localparam int unsigned IW    = (CHAIN_LEN > 1) ? $clog2(CHAIN_LEN) : 1;
  localparam logic [5:0]  OFF_REJ = 6'(SLOTS);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_TK_WAIT = 4'd1;
  localparam logic [3:0] S_TK_EMIT = 4'd2;
  localparam logic [3:0] S_START   = 4'd3;
  localparam logic [3:0] S_SR_RD   = 4'd4;
  localparam logic [3:0] S_SR_CHK  = 4'd5;
  localparam logic [3:0] S_SR_MOD  = 4'd6;
  localparam logic [3:0] S_PL_RD   = 4'd7;
  localparam logic [3:0] S_PL_CHK  = 4'd8;
  localparam logic [3:0] S_PL_MOD  = 4'd9;
  localparam logic [3:0] S_PL_ERD  = 4'd10;
  localparam logic [3:0] S_PL_ECHK = 4'd11;
  localparam logic [3:0] S_RES     = 4'd12;

  function automatic logic [ROW_W-1:0] set_byte(input logic [ROW_W-1:0] row,
                                                input logic [WW-1:0] idx,
                                                input logic [7:0] val);
    logic [ROW_W-1:0] r;
    r = row;
    for (int w = 0; w < WAYS; w++) begin
      if (WW'(w) == idx) r[w*8 +: 8] = val;
    end
    return r;
  endfunction

  logic [3:0]       state_q, state_d;
  logic [SW-1:0]    ptr_q, ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    i_q, i_d;
  logic [OW-1:0]    off_q, off_d;
  logic [SW-1:0]    base_q, base_d;
  logic [SW-1:0]    cur_q, cur_d;
  logic [EW-1:0]    sum_q, sum_d;
  logic             endph_q, endph_d;
  logic             rej_q, rej_d;
  logic [3:0]       drop_q, drop_d;
  logic [SW-1:0]    s_q, s_d;
  logic [WW-1:0]    w_q, w_d;
  logic [ROW_W-1:0] rows_q, rows_d;
  logic [ROW_W-1:0] tkrow_q, tkrow_d;

  logic             out_valid_q, out_valid_d;
  tws_pkg::kind_e   out_kind_q, out_kind_d;
  logic [7:0]       out_tid_q, out_tid_d;
  logic [4:0]       out_slot_q, out_slot_d;
  logic [5:0]       out_off_q, out_off_d;
  logic [3:0]       out_drop_q, out_drop_d;
  logic             out_last_q, out_last_d;

  logic [7:0] buf_task_q [CHAIN_LEN];
  logic [4:0] buf_dur_q  [CHAIN_LEN];
  logic [7:0] buf_end_q  [CHAIN_LEN];

  tws_pkg::mem_cmd_t mcmd;
  logic [SW-1:0]    wr_addr, rd_addr;
  logic [ROW_W-1:0] wr_data, rd_data;

  logic          in_acc, out_free, buf_we, i_done;
  logic [7:0]    act_task, act_end;
  logic [4:0]    act_dur;
  logic          fw_found;
  logic [WW-1:0] fw_idx;
  logic [WAYS-1:0] tk_mask;
  logic          tk_any, tk_one;
  logic [WW-1:0] tk_idx;
  logic [SW-1:0] ptr_inc, base_inc;
  logic [15:0]   base_ext, off_ext, ptr_ext;

  tws_wheel_mem #(
    .SLOTS (SLOTS),
    .ROW_W (ROW_W),
    .AW    (SW)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (mcmd),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .clr_addr_i (ptr_q),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign buf_we   = in_acc && s_axis_tuser_i && (cnt_q < CW'(CHAIN_LEN));
  assign rd_addr  = (state_q == S_IDLE) ? ptr_q : cur_q;

  assign act_task = buf_task_q[i_q[IW-1:0]];
  assign act_dur  = buf_dur_q[i_q[IW-1:0]];
  assign act_end  = buf_end_q[i_q[IW-1:0]];
  assign i_done   = (i_q == cnt_q) || (act_task == 8'd0);

  assign ptr_inc  = (ptr_q == SW'(SLOTS - 1)) ? '0 : ptr_q + 1'b1;
  assign base_inc = (base_q == SW'(SLOTS - 1)) ? '0 : base_q + 1'b1;
  assign base_ext = 16'(base_q);
  assign off_ext  = 16'(off_q);
  assign ptr_ext  = 16'(ptr_q);

  // first free way of the row just read
  always_comb begin
    fw_found = 1'b0;
    fw_idx   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rd_data[w*8 +: 8] == 8'd0) begin
        fw_found = 1'b1;
        fw_idx   = WW'(w);
      end
    end
  end

  // lowest occupied way of the slot being executed
  always_comb begin
    tk_idx = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      tk_mask[w] = (tkrow_q[w*8 +: 8] != 8'd0);
      if (tkrow_q[w*8 +: 8] != 8'd0) tk_idx = WW'(w);
    end
    tk_any = |tk_mask;
    tk_one = ((tk_mask & (tk_mask - 1'b1)) == '0);
  end

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    cnt_d   = cnt_q;
    i_d     = i_q;
    off_d   = off_q;
    base_d  = base_q;
    cur_d   = cur_q;
    sum_d   = sum_q;
    endph_d = endph_q;
    rej_d   = rej_q;
    drop_d  = drop_q;
    s_d     = s_q;
    w_d     = w_q;
    rows_d  = rows_q;
    tkrow_d = tkrow_q;
    mcmd    = '0;
    wr_addr = cur_q;
    wr_data = rows_q;

    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_kind_d  = out_kind_q;
    out_tid_d   = out_tid_q;
    out_slot_d  = out_slot_q;
    out_off_d   = out_off_q;
    out_drop_d  = out_drop_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!s_axis_tuser_i) begin
            state_d = S_TK_WAIT;
          end else begin
            if (buf_we) cnt_d = cnt_q + 1'b1;
            if (s_axis_tlast_i) begin
              i_d     = '0;
              state_d = S_START;
            end
          end
        end
      end
      S_TK_WAIT: begin
        tkrow_d = rd_data;
        state_d = S_TK_EMIT;
      end
      S_TK_EMIT: begin
        if (!tk_any) begin
          mcmd.clr = 1'b1;
          ptr_d    = ptr_inc;
          state_d  = S_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = tws_pkg::KIND_EXEC;
          out_tid_d   = tkrow_q[tk_idx*8 +: 8];
          out_slot_d  = ptr_ext[4:0];
          out_off_d   = '0;
          out_drop_d  = '0;
          out_last_d  = tk_one;
          tkrow_d     = set_byte(tkrow_q, tk_idx, 8'd0);
        end
      end
      S_START: begin
        base_d  = ptr_q;
        cur_d   = ptr_q;
        off_d   = '0;
        endph_d = 1'b0;
        drop_d  = '0;
        if (i_done) begin
          rej_d   = 1'b1;
          state_d = S_RES;
        end else begin
          state_d = S_SR_RD;
        end
      end
      S_SR_RD: begin
        if (!endph_q && i_done) begin
          i_d     = '0;
          cur_d   = base_q;
          state_d = S_PL_RD;
        end else begin
          state_d = S_SR_CHK;
        end
      end
      S_SR_CHK: begin
        if (!fw_found) begin
          if (off_q == OW'(SLOTS - 1)) begin
            rej_d   = 1'b1;
            state_d = S_RES;
          end else begin
            off_d   = off_q + 1'b1;
            base_d  = base_inc;
            cur_d   = base_inc;
            i_d     = '0;
            endph_d = 1'b0;
            state_d = S_SR_RD;
          end
        end else if (!endph_q && act_dur != 5'd0) begin
          sum_d   = EW'(cur_q) + EW'(act_dur);
          endph_d = 1'b1;
          state_d = S_SR_MOD;
        end else begin
          endph_d = 1'b0;
          i_d     = i_q + 1'b1;
          state_d = S_SR_RD;
        end
      end
      S_SR_MOD: begin
        // wrap the end slot one subtraction a cycle
        if (sum_q >= EW'(SLOTS)) begin
          sum_d = sum_q - EW'(SLOTS);
        end else begin
          cur_d   = sum_q[SW-1:0];
          state_d = S_SR_RD;
        end
      end
      S_PL_RD: begin
        if (i_done) begin
          rej_d   = 1'b0;
          state_d = S_RES;
        end else begin
          state_d = S_PL_CHK;
        end
      end
      S_PL_CHK: begin
        if (!fw_found) begin
          i_d     = i_q + 1'b1;
          state_d = S_PL_RD;
        end else begin
          mcmd.wr = 1'b1;
          wr_data = set_byte(rd_data, fw_idx, act_task);
          rows_d  = set_byte(rd_data, fw_idx, act_task);
          s_d     = cur_q;
          w_d     = fw_idx;
          if (act_dur == 5'd0) begin
            i_d     = i_q + 1'b1;
            state_d = S_PL_RD;
          end else begin
            sum_d   = EW'(cur_q) + EW'(act_dur);
            state_d = S_PL_MOD;
          end
        end
      end
      S_PL_MOD: begin
        if (sum_q >= EW'(SLOTS)) begin
          sum_d = sum_q - EW'(SLOTS);
        end else begin
          cur_d   = sum_q[SW-1:0];
          state_d = S_PL_ERD;
        end
      end
      S_PL_ERD: begin
        state_d = S_PL_ECHK;
      end
      S_PL_ECHK: begin
        if (fw_found) begin
          mcmd.wr = 1'b1;
          if (act_end != 8'd0) begin
            wr_data = set_byte(rd_data, fw_idx, act_end);
          end else begin
            // end task missing: take the start entry back out
            wr_addr = s_q;
            wr_data = set_byte(rows_q, w_q, 8'd0);
            if (drop_q != 4'hF) drop_d = drop_q + 1'b1;
          end
        end
        i_d     = i_q + 1'b1;
        state_d = S_PL_RD;
      end
      S_RES: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = rej_q ? tws_pkg::KIND_REJECTED : tws_pkg::KIND_PLACED;
          out_tid_d   = '0;
          out_slot_d  = rej_q ? 5'd0 : base_ext[4:0];
          out_off_d   = rej_q ? OFF_REJ : off_ext[5:0];
          out_drop_d  = rej_q ? 4'd0 : drop_q;
          out_last_d  = 1'b1;
          cnt_d       = '0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    off_q      <= off_d;
    base_q     <= base_d;
    cur_q      <= cur_d;
    sum_q      <= sum_d;
    endph_q    <= endph_d;
    rej_q      <= rej_d;
    drop_q     <= drop_d;
    s_q        <= s_d;
    w_q        <= w_d;
    rows_q     <= rows_d;
    tkrow_q    <= tkrow_d;
    out_kind_q <= out_kind_d;
    out_tid_q  <= out_tid_d;
    out_slot_q <= out_slot_d;
    out_off_q  <= out_off_d;
    out_drop_q <= out_drop_d;
    out_last_q <= out_last_d;
    if (buf_we) begin
      buf_task_q[cnt_q[IW-1:0]] <= s_axis_tdata_i[7:0];
      buf_dur_q[cnt_q[IW-1:0]]  <= s_axis_tdata_i[12:8];
      buf_end_q[cnt_q[IW-1:0]]  <= s_axis_tdata_i[20:13];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_drop_q, out_off_q, out_slot_q, out_tid_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef NO_ASSERTIONS
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ptr_q) < SLOTS)
    else $error("wheel pointer out of range");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CHAIN_LEN))
    else $error("chain count beyond buffer depth");

  a_tick_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !s_axis_tuser_i) |=> (state_q == S_TK_WAIT))
    else $error("tick request did not start a slot read");

  a_cur_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SR_CHK || state_q == S_PL_CHK || state_q == S_PL_ECHK)
      |-> (32'(cur_q) < SLOTS))
    else $error("running slot out of range at row check");

  a_no_write_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TK_EMIT) |-> !mcmd.wr)
    else $error("wheel write while a slot is executed");
`endif

endmodule

// ----- sv/tws_wheel_mem.sv -----
// wheel row memory: one row of WAYS task ids per slot, with a registered read
// row valid flags make every row read as empty after reset; depends on tws_pkg
module tws_wheel_mem #(
  parameter int unsigned SLOTS = 32,
  parameter int unsigned ROW_W = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tws_pkg::mem_cmd_t     cmd_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  logic [ROW_W-1:0]      wr_data_i,
  input  logic [AW-1:0]         clr_addr_i,
  input  logic [AW-1:0]         rd_addr_i,
  output logic [ROW_W-1:0]      rd_data_o
);

  logic [ROW_W-1:0] mem [SLOTS];
  logic [SLOTS-1:0] vld_q;
  logic [ROW_W-1:0] rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.wr) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (cmd_i.clr) begin
        vld_q[clr_addr_i] <= 1'b0;
      end
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule
